/* hdl/dmadcb_pkg.sv */
// Shared constants, types and helpers of the descriptor chain builder.
package dmadcb_pkg;

    // Chain geometry.
    localparam int MAX_ITEMS   = 64;
    localparam int CHUNK_BYTES = 4095;
    localparam int LEN_LIMIT   = MAX_ITEMS * CHUNK_BYTES;
    localparam int DESC_STRIDE = 16;

    // Field widths.
    localparam int ADDR_W  = 32;
    localparam int COUNT_W = 18;
    localparam int IDX_W   = 6;
    localparam int WID_W   = 2;
    localparam int PERI_W  = 4;
    localparam int SIZE_W  = 19;

    // Stream payload widths.
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 168;

    // Configuration port.
    localparam int   CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUMMY     = 1'b1;

    // Request kinds.
    localparam logic REQ_RX = 1'b0;
    localparam logic REQ_TX = 1'b1;

    // Flow control codes of the channel configuration word.
    localparam logic [3:0] FLOW_RX = 4'd2;
    localparam logic [3:0] FLOW_TX = 4'd1;

    typedef struct packed {
        logic load;   // latch a new request
        logic step;   // build one descriptor into the output register
    } t_cmd;

    typedef struct packed {
        logic fin;    // the descriptor built next is the final one
    } t_sts;

    function automatic logic [31:0] pack_control(
        input logic              irq,
        input logic              dinc,
        input logic              sinc,
        input logic              dmst,
        input logic              smst,
        input logic [WID_W-1:0]  dw,
        input logic [WID_W-1:0]  sw,
        input logic [1:0]        db,
        input logic [1:0]        sb,
        input logic [SIZE_W-1:0] size
    );
        return {irq, dinc, sinc, dmst, smst, dw, sw, db, sb, size};
    endfunction

    function automatic logic [31:0] pack_chcfg(
        input logic              tx,
        input logic [PERI_W-1:0] peri
    );
        logic [31:0] w;
        w = 32'h0300_C000;
        if (tx == REQ_TX) begin
            w = w | ({28'd0, FLOW_TX} << 11) | ({28'd0, peri} << 6);
        end else begin
            w = w | ({28'd0, FLOW_RX} << 11) | ({28'd0, peri} << 1);
        end
        return w;
    endfunction

endpackage

/* hdl/dma_descriptor_chain_builder.sv */
// Top level of the DMA linked-list descriptor chain builder.
//
// One transfer request on the slave stream becomes a chain of linked-list
// descriptors on the master stream, one transfer per descriptor, in chain
// order, with tlast on the final one. The byte count is cut into chunks of
// 4095 bytes; a count of zero gives one zero-length descriptor, and a count
// above 64 chunks gives a single transfer with the too_long flag set and
// all other fields zero. A request is latched into the working
// registers, then one descriptor is built per cycle, while the master side
// does not stall, by the chunk-step loop of the datapath (memory address,
// remaining count, link and index registers). A request yields
// ceil(byte_count / 4095) descriptors, or one for a zero count or a
// too-long request. The last descriptor sits in the
// output register while the next request is already accepted. The two
// configuration registers (list base, dummy word address) are written over
// the cfg channel, which is always ready; write them only while idle.
module dma_descriptor_chain_builder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dmadcb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    // Request stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] periph_addr, [63:32] mem_addr, [81:64] byte_count,
    // [83:82] dst_wcode, [85:84] src_wcode, [89:86] peripheral, rest zero
    input  logic [dmadcb_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // [0] req_type
    input  logic                                i_s_axis_tuser,
    // Descriptor stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [5:0] item_index, [37:6] src_ptr, [69:38] dst_ptr,
    // [101:70] next_link, [133:102] control_word,
    // [165:134] channel_config, rest zero
    output logic [dmadcb_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // last
    output logic                                o_m_axis_tlast,
    // [0] too_long
    output logic                                o_m_axis_tuser
);
    import dmadcb_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [IDX_W-1:0]   item_index;
    logic [ADDR_W-1:0]  src_ptr, dst_ptr, next_link;
    logic [31:0]        control_word, channel_config;

    // Writes always complete at once.
    assign o_cfg_ready = 1'b1;

    dmadcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dmadcb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_req_type       (i_s_axis_tuser),
        .i_periph_addr    (i_s_axis_tdata[31:0]),
        .i_mem_addr       (i_s_axis_tdata[63:32]),
        .i_byte_count     (i_s_axis_tdata[81:64]),
        .i_dst_wcode      (i_s_axis_tdata[83:82]),
        .i_src_wcode      (i_s_axis_tdata[85:84]),
        .i_peripheral     (i_s_axis_tdata[89:86]),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_item_index     (item_index),
        .o_src_ptr        (src_ptr),
        .o_dst_ptr        (dst_ptr),
        .o_next_link      (next_link),
        .o_control_word   (control_word),
        .o_channel_config (channel_config),
        .o_last           (o_m_axis_tlast),
        .o_too_long       (o_m_axis_tuser)
    );

    // Pack the descriptor fields, lowest field first.
    assign o_m_axis_tdata = {2'b00, channel_config, control_word, next_link,
                             dst_ptr, src_ptr, item_index};

endmodule

/* hdl/dmadcb_ctrl.sv */
// Controller state machine of the descriptor chain builder.
module dmadcb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  dmadcb_pkg::t_sts i_sts,
    output dmadcb_pkg::t_cmd o_cmd
);
    import dmadcb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_GEN  = 1'b1;

    logic r_state, n_state;
    logic r_vld, n_vld;
    logic out_free;

    assign out_free    = !r_vld || i_out_ready;
    assign o_req_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_vld;
    assign o_cmd.load  = i_req_valid && (r_state == ST_IDLE);
    assign o_cmd.step  = (r_state == ST_GEN) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) n_state = ST_GEN;
            end
            ST_GEN: begin
                if (o_cmd.step && i_sts.fin) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        if (o_cmd.step) begin
            n_vld = 1'b1;
        end else if (i_out_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
        end
    end

endmodule

/* hdl/dmadcb_dp.sv */
// Datapath of the descriptor chain builder: registers, working state, output register.
module dmadcb_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dmadcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    input  logic                              i_req_type,
    input  logic [dmadcb_pkg::ADDR_W-1:0]     i_periph_addr,
    input  logic [dmadcb_pkg::ADDR_W-1:0]     i_mem_addr,
    input  logic [dmadcb_pkg::COUNT_W-1:0]    i_byte_count,
    input  logic [dmadcb_pkg::WID_W-1:0]      i_dst_wcode,
    input  logic [dmadcb_pkg::WID_W-1:0]      i_src_wcode,
    input  logic [dmadcb_pkg::PERI_W-1:0]     i_peripheral,
    input  dmadcb_pkg::t_cmd                  i_cmd,
    output dmadcb_pkg::t_sts                  o_sts,
    output logic [dmadcb_pkg::IDX_W-1:0]      o_item_index,
    output logic [dmadcb_pkg::ADDR_W-1:0]     o_src_ptr,
    output logic [dmadcb_pkg::ADDR_W-1:0]     o_dst_ptr,
    output logic [dmadcb_pkg::ADDR_W-1:0]     o_next_link,
    output logic [31:0]                       o_control_word,
    output logic [31:0]                       o_channel_config,
    output logic                              o_last,
    output logic                              o_too_long
);
    import dmadcb_pkg::*;

    // Configuration registers.
    logic [ADDR_W-1:0]  r_list_base, r_dummy;

    // Working state of the request in progress.
    logic               r_tx, r_inc, r_too_long;
    logic [ADDR_W-1:0]  r_paddr, r_mem, r_link;
    logic [COUNT_W-1:0] r_rest;
    logic [WID_W-1:0]   r_dw, r_sw;
    logic [31:0]        r_chcfg;
    logic [IDX_W-1:0]   r_idx;

    // Output register.
    logic [IDX_W-1:0]   r_o_idx;
    logic [ADDR_W-1:0]  r_o_src, r_o_dest, r_o_link;
    logic [31:0]        r_o_ctrl, r_o_chcfg;
    logic               r_o_last, r_o_too_long;

    logic               fin;
    logic [SIZE_W-1:0]  size;
    logic [31:0]        ctrl;

    assign fin       = r_too_long || (r_rest <= COUNT_W'(CHUNK_BYTES));
    assign o_sts.fin = fin;
    assign size      = fin ? SIZE_W'(r_rest) : SIZE_W'(CHUNK_BYTES);

    always_comb begin
        if (r_tx == REQ_TX) begin
            ctrl = pack_control(fin, 1'b0, r_inc, 1'b1, 1'b0, r_dw, r_sw,
                                {1'b0, fin}, {1'b0, fin}, size);
        end else begin
            ctrl = pack_control(fin, r_inc, 1'b0, 1'b0, 1'b1, r_dw, r_sw,
                                2'd1, 2'd1, size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_base <= '0;
            r_dummy     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LIST_BASE: r_list_base <= i_cfg_data;
                CFG_DUMMY:     r_dummy     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tx       <= i_req_type;
            r_paddr    <= i_periph_addr;
            r_dw       <= i_dst_wcode;
            r_sw       <= i_src_wcode;
            r_rest     <= i_byte_count;
            r_too_long <= (i_byte_count > COUNT_W'(LEN_LIMIT));
            r_chcfg    <= pack_chcfg(i_req_type, i_peripheral);
            r_idx      <= '0;
            r_link     <= r_list_base + ADDR_W'(DESC_STRIDE);
            if (i_mem_addr != '0) begin
                r_mem <= i_mem_addr;
                r_inc <= 1'b1;
            end else begin
                r_mem <= r_dummy;
                r_inc <= 1'b0;
            end
        end else if (i_cmd.step) begin
            // Advance to the next chunk; unused after the final descriptor.
            r_mem  <= r_mem + ADDR_W'(CHUNK_BYTES);
            r_rest <= r_rest - COUNT_W'(CHUNK_BYTES);
            r_link <= r_link + ADDR_W'(DESC_STRIDE);
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_o_last     <= fin;
            r_o_too_long <= r_too_long;
            if (r_too_long) begin
                r_o_idx   <= '0;
                r_o_src   <= '0;
                r_o_dest  <= '0;
                r_o_link  <= '0;
                r_o_ctrl  <= '0;
                r_o_chcfg <= '0;
            end else begin
                r_o_idx   <= r_idx;
                r_o_src   <= (r_tx == REQ_TX) ? r_mem : r_paddr;
                r_o_dest  <= (r_tx == REQ_TX) ? r_paddr : r_mem;
                r_o_link  <= fin ? '0 : r_link;
                r_o_ctrl  <= ctrl;
                r_o_chcfg <= r_chcfg;
            end
        end
    end

    assign o_item_index     = r_o_idx;
    assign o_src_ptr        = r_o_src;
    assign o_dst_ptr        = r_o_dest;
    assign o_next_link      = r_o_link;
    assign o_control_word   = r_o_ctrl;
    assign o_channel_config = r_o_chcfg;
    assign o_last           = r_o_last;
    assign o_too_long       = r_o_too_long;

endmodule
